### hdl/pcc_pkg.sv
// Peak capture package: record and row types, record kind codes, defaults.
// No dependencies; used by every module of the peak capture block.
`default_nettype none

package pcc_pkg;

  localparam int CHANNELS_DEF = 3;
  localparam int KINDS        = 4;
  localparam int DATA_W       = 16;
  localparam int MAG_W        = 15;

  localparam logic [1:0] K_MAX_T = 2'd0;
  localparam logic [1:0] K_MIN_T = 2'd1;
  localparam logic [1:0] K_MAX_W = 2'd2;
  localparam logic [1:0] K_MIN_W = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] ten;
    logic [DATA_W-1:0] wnd;
    logic [DATA_W-1:0] tlt;
  } rec_t;

  typedef rec_t [KINDS-1:0] row_t;

endpackage

`default_nettype wire

### hdl/pcc_update.sv
// Peak capture record update: next row of one channel from a sample.
// Depends on pcc_pkg.
`default_nettype none

module pcc_update (
  input  pcc_pkg::row_t row,
  input  logic          armed,
  input  logic [15:0]   tension,
  input  logic [15:0]   wind_angle,
  input  logic [15:0]   tilt,
  input  logic          tension_valid,
  input  logic          wind_valid,
  output pcc_pkg::row_t row_next
);
  import pcc_pkg::*;

  rec_t smp;
  row_t base;

  assign smp = '{ten: tension, wnd: wind_angle, tlt: tilt};

  always_comb begin
    base = row;
    if (!armed) begin
      base[K_MAX_T] = tension_valid ? smp : '0;
      base[K_MIN_T] = tension_valid ? smp : '0;
      base[K_MAX_W] = wind_valid ? smp : '0;
      base[K_MIN_W] = wind_valid ? smp : '0;
    end
    row_next = base;
    if (tension_valid) begin
      if (tension > base[K_MAX_T].ten) begin
        row_next[K_MAX_T] = smp;
      end else if (tension < base[K_MIN_T].ten) begin
        row_next[K_MIN_T] = smp;
      end
    end
    if (wind_valid) begin
      if (wind_angle[MAG_W-1:0] > base[K_MAX_W].wnd[MAG_W-1:0]) begin
        row_next[K_MAX_W] = smp;
      end else if (wind_angle[MAG_W-1:0] < base[K_MIN_W].wnd[MAG_W-1:0]) begin
        row_next[K_MIN_W] = smp;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/pcc_report.sv
// Peak capture report buffer: holds a snapshot of one row and sends its
// four records as output words. Depends on pcc_pkg.
`default_nettype none

module pcc_report (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  pcc_pkg::row_t row,
  output logic          free,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    record_kind,
  output logic [15:0]   rec_tension,
  output logic [15:0]   rec_wind,
  output logic [15:0]   rec_tilt,
  output logic          last
);
  import pcc_pkg::*;

  logic       busy;
  logic [1:0] kind;
  row_t       snap;

  assign free        = !busy || (out_ready && kind == K_MIN_W);
  assign out_valid   = busy;
  assign record_kind = kind;
  assign rec_tension = snap[kind].ten;
  assign rec_wind    = snap[kind].wnd;
  assign rec_tilt    = snap[kind].tlt;
  assign last        = (kind == K_MIN_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      kind <= K_MAX_T;
    end else if (load) begin
      busy <= 1'b1;
      kind <= K_MAX_T;
    end else if (busy && out_ready) begin
      if (kind == K_MIN_W) begin
        busy <= 1'b0;
      end
      kind <= kind + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      snap <= row;
    end
  end

endmodule

`default_nettype wire

### hdl/peak_capture_with_companions_unit.sv
// Peak capture top level: input register, per-channel record store and
// arm flags. Depends on pcc_pkg, pcc_update and pcc_report.
//
// Keeps, per channel, the records of maximum and minimum tension and of
// maximum and minimum wind magnitude, each with its tension, wind and tilt.
// A sample word passes through the input register to a single
// compare-and-update of the channel's row, and a new word is taken every
// cycle while no report waits for the buffer. A report word snapshots the
// row into the report buffer and disarms the channel, so its next sample
// starts fresh records; the four snapshot records then leave one per cycle
// on the output port while out_ready is high, and later samples keep
// flowing. A second report waits only until the buffer hands out the last
// record of the one before. Channels at or above CHANNELS are dropped without effect.
`default_nettype none

module peak_capture_with_companions_unit #(
  parameter int CHANNELS = pcc_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [1:0]  channel,
  input  logic [15:0] tension,
  input  logic [15:0] wind_angle,
  input  logic [15:0] tilt,
  input  logic        tension_valid,
  input  logic        wind_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  record_kind,
  output logic [15:0] rec_tension,
  output logic [15:0] rec_wind,
  output logic [15:0] rec_tilt,
  output logic        last
);
  import pcc_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic              held;
  logic              cmd_q;
  logic [1:0]        channel_q;
  logic [15:0]       tension_q;
  logic [15:0]       wind_q;
  logic [15:0]       tilt_q;
  logic              tv_q;
  logic              wv_q;

  row_t              rows [CHANNELS];
  logic [CHANNELS-1:0] armed;

  logic [IDX_W-1:0]  idx;
  logic              in_range;
  logic              rpt_free;
  logic              fire;
  logic              upd_en;
  logic              rpt_load;
  row_t              row_cur;
  row_t              row_next;

  assign idx      = IDX_W'(channel_q);
  assign in_range = ({30'd0, channel_q} < 32'(CHANNELS));
  assign row_cur  = rows[idx];
  assign fire     = held && (!cmd_q || !in_range || rpt_free);
  assign upd_en   = fire && !cmd_q && in_range;
  assign rpt_load = fire && cmd_q && in_range;
  assign in_ready = !held || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q     <= cmd;
      channel_q <= channel;
      tension_q <= tension;
      wind_q    <= wind_angle;
      tilt_q    <= tilt;
      tv_q      <= tension_valid;
      wv_q      <= wind_valid;
    end
  end

  pcc_update u_update (
    .row           (row_cur),
    .armed         (armed[idx]),
    .tension       (tension_q),
    .wind_angle    (wind_q),
    .tilt          (tilt_q),
    .tension_valid (tv_q),
    .wind_valid    (wv_q),
    .row_next      (row_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        rows[i] <= '0;
      end
    end else if (upd_en) begin
      armed[idx] <= 1'b1;
      rows[idx]  <= row_next;
    end else if (rpt_load) begin
      armed[idx] <= 1'b0;
    end
  end

  pcc_report u_report (
    .clk         (clk),
    .rst         (rst),
    .load        (rpt_load),
    .row         (row_cur),
    .free        (rpt_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .record_kind (record_kind),
    .rec_tension (rec_tension),
    .rec_wind    (rec_wind),
    .rec_tilt    (rec_tilt),
    .last        (last)
  );

`ifndef ASSERT_OFF
  a_report_starts: assert property (@(posedge clk) disable iff (rst)
    rpt_load |=> out_valid && record_kind == K_MAX_T)
    else $error("report did not start with the max tension record");

  a_last_on_fourth: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (record_kind == K_MIN_W)))
    else $error("last flag out of step with record kind");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> held && cmd_q && in_range && !rpt_free)
    else $error("input stalled without a blocked report");

  a_sample_arms: assert property (@(posedge clk) disable iff (rst)
    upd_en |=> armed[$past(idx)])
    else $error("sample left its channel disarmed");
`endif

endmodule

`default_nettype wire

### test/peak_record_checker.sv
// Peak capture checker: tracks per-channel extreme records from the accepted
// words and compares every record the block reports. Depends on pcc_pkg.
module peak_record_checker #(
  parameter int CHANNELS = pcc_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        cmd,
  input  logic [1:0]  channel,
  input  logic [15:0] tension,
  input  logic [15:0] wind_angle,
  input  logic [15:0] tilt,
  input  logic        tension_valid,
  input  logic        wind_valid,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  record_kind,
  input  logic [15:0] rec_tension,
  input  logic [15:0] rec_wind,
  input  logic [15:0] rec_tilt,
  input  logic        last,
  output int          mismatches,
  output int          records_pending,
  output int          records_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import pcc_pkg::*;

  localparam logic CMD_REPORT = 1'b1;
  localparam logic [MAG_W-1:0] MAG_MASK = 15'h7fff;

  typedef struct packed {
    logic [1:0] kind;
    rec_t       rec;
    logic       last;
  } report_rec_t;

  rec_t        extremes [CHANNELS][KINDS];
  bit          armed [CHANNELS];
  report_rec_t awaited_records [$];
  report_rec_t want;
  int          err_cnt;
  int          seen_cnt;

  task automatic track_word(input logic c, input logic [1:0] ch, input logic [15:0] t,
                            input logic [15:0] w, input logic [15:0] q, input logic tv,
                            input logic wv);
    rec_t        smp;
    rec_t        zero;
    report_rec_t r;
    smp.ten = t;
    smp.wnd = w;
    smp.tlt = q;
    zero = '0;
    if (ch < CHANNELS) begin
      if (c == CMD_REPORT) begin
        for (int k = 0; k < KINDS; k++) begin
          r.kind = 2'(k);
          r.rec = extremes[ch][k];
          r.last = (k == KINDS - 1);
          awaited_records.push_back(r);
        end
        armed[ch] = 1'b0;
      end else begin
        if (!armed[ch]) begin
          armed[ch] = 1'b1;
          extremes[ch][K_MAX_T] = tv ? smp : zero;
          extremes[ch][K_MIN_T] = tv ? smp : zero;
          extremes[ch][K_MAX_W] = wv ? smp : zero;
          extremes[ch][K_MIN_W] = wv ? smp : zero;
        end
        if (tv) begin
          if (t > extremes[ch][K_MAX_T].ten)
            extremes[ch][K_MAX_T] = smp;
          else if (t < extremes[ch][K_MIN_T].ten)
            extremes[ch][K_MIN_T] = smp;
        end
        if (wv) begin
          if ((w[MAG_W-1:0] & MAG_MASK) >
              (extremes[ch][K_MAX_W].wnd[MAG_W-1:0] & MAG_MASK))
            extremes[ch][K_MAX_W] = smp;
          else if ((w[MAG_W-1:0] & MAG_MASK) <
                   (extremes[ch][K_MIN_W].wnd[MAG_W-1:0] & MAG_MASK))
            extremes[ch][K_MIN_W] = smp;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        armed[c] = 1'b0;
        for (int k = 0; k < KINDS; k++)
          extremes[c][k] = '0;
      end
      awaited_records.delete();
      err_cnt = 0;
      seen_cnt = 0;
    end else begin
      if (in_valid && in_ready)
        track_word(cmd, channel, tension, wind_angle, tilt, tension_valid, wind_valid);
      if (out_valid && out_ready) begin
        seen_cnt++;
        if (awaited_records.size() == 0) begin
          if (err_cnt < 10)
            $display("%0t: record with none awaited: kind %0d ten %h wnd %h tlt %h last %0d",
                     $realtime, record_kind, rec_tension, rec_wind, rec_tilt, last);
          err_cnt++;
        end else begin
          want = awaited_records.pop_front();
          if (want.kind !== record_kind || want.rec.ten !== rec_tension ||
              want.rec.wnd !== rec_wind || want.rec.tlt !== rec_tilt ||
              want.last !== last) begin
            if (err_cnt < 10) begin
              $display("%0t: record mismatch: want kind %0d ten %h wnd %h tlt %h last %0d",
                       $realtime, want.kind, want.rec.ten, want.rec.wnd, want.rec.tlt,
                       want.last);
              $display("  got kind %0d ten %h wnd %h tlt %h last %0d",
                       record_kind, rec_tension, rec_wind, rec_tilt, last);
            end
            err_cnt++;
          end
        end
      end
    end
    mismatches <= err_cnt;
    records_pending <= awaited_records.size();
    records_seen <= seen_cnt;
  end

endmodule

### test/tb_peak_capture_with_companions_unit.sv
// Peak capture testbench top: drives sample and report words under mixed
// sender idling and receiver stalls. Depends on pcc_pkg, the block and
// peak_record_checker, which predicts and compares the reported records.
module tb_peak_capture_with_companions_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   CHANNELS     = pcc_pkg::CHANNELS_DEF;
  localparam int   RANDOM_WORDS = 120;
  localparam int   STALL_LIMIT  = 2000;
  localparam int   DRAIN_CYCLES = 20;
  localparam logic CMD_SAMPLE   = 1'b0;
  localparam logic CMD_REPORT   = 1'b1;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = CMD_SAMPLE;
  logic [1:0]  channel = '0;
  logic [15:0] tension = '0;
  logic [15:0] wind_angle = '0;
  logic [15:0] tilt = '0;
  logic        tension_valid = 1'b0;
  logic        wind_valid = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [1:0]  record_kind;
  logic [15:0] rec_tension;
  logic [15:0] rec_wind;
  logic [15:0] rec_tilt;
  logic        last;

  int mismatches;
  int records_pending;
  int records_seen;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_sent = 0;
  int reports_sent = 0;
  int ignored_sent = 0;
  int counted = 0;
  int quiet_cycles = 0;

  peak_capture_with_companions_unit #(.CHANNELS(CHANNELS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .channel(channel), .tension(tension), .wind_angle(wind_angle),
    .tilt(tilt), .tension_valid(tension_valid), .wind_valid(wind_valid),
    .out_valid(out_valid), .out_ready(out_ready),
    .record_kind(record_kind), .rec_tension(rec_tension), .rec_wind(rec_wind),
    .rec_tilt(rec_tilt), .last(last)
  );

  peak_record_checker #(.CHANNELS(CHANNELS)) records_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .channel(channel), .tension(tension), .wind_angle(wind_angle),
    .tilt(tilt), .tension_valid(tension_valid), .wind_valid(wind_valid),
    .out_valid(out_valid), .out_ready(out_ready),
    .record_kind(record_kind), .rec_tension(rec_tension), .rec_wind(rec_wind),
    .rec_tilt(rec_tilt), .last(last),
    .mismatches(mismatches), .records_pending(records_pending),
    .records_seen(records_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no word moved for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic [15:0] pick_reading();
    case ($urandom_range(7))
      0: pick_reading = 16'h0000;
      1: pick_reading = 16'hffff;
      2: pick_reading = 16'h7fff;
      3: pick_reading = 16'h8000;
      default: pick_reading = 16'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic c, input logic [1:0] ch, input logic [15:0] t,
                           input logic [15:0] w, input logic [15:0] q, input logic tv,
                           input logic wv);
    bit idled;
    idled = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      if (!idled)
        in_valid <= 1'b0;
      idled = 1'b1;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    channel <= ch;
    tension <= t;
    wind_angle <= w;
    tilt <= q;
    tension_valid <= tv;
    wind_valid <= wv;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (ch >= CHANNELS)
      ignored_sent++;
    else if (c == CMD_REPORT)
      reports_sent++;
  endtask

  task automatic drain_records();
    in_valid <= 1'b0;
    do @(posedge clk); while (records_pending != 0);
  endtask

  initial begin
    logic        c;
    logic [1:0]  ch;
    logic        tv;
    logic        wv;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_word(CMD_REPORT, 2'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_word(CMD_SAMPLE, 2'd0, 16'hffff, 16'hffff, 16'hffff, 1'b0, 1'b0);
    send_word(CMD_SAMPLE, 2'd0, 16'h1234, 16'h8001, 16'h00aa, 1'b1, 1'b1);
    send_word(CMD_REPORT, 2'd0, 16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b1);
    send_word(CMD_SAMPLE, 2'd1, 16'h8000, 16'h8005, 16'hffff, 1'b1, 1'b1);
    send_word(CMD_SAMPLE, 2'd1, 16'hffff, 16'h7fff, 16'h0001, 1'b1, 1'b1);
    send_word(CMD_SAMPLE, 2'd1, 16'h0000, 16'h8000, 16'h0002, 1'b1, 1'b1);
    send_word(CMD_SAMPLE, 2'd1, 16'h8000, 16'h0000, 16'h0003, 1'b1, 1'b1);
    send_word(CMD_SAMPLE, 2'd1, 16'hffff, 16'hffff, 16'h0004, 1'b1, 1'b1);
    send_word(CMD_SAMPLE, 2'd1, 16'h0000, 16'h0000, 16'h0005, 1'b0, 1'b0);
    send_word(CMD_SAMPLE, 2'd1, 16'haaaa, 16'h7ffe, 16'h0006, 1'b0, 1'b1);
    send_word(CMD_REPORT, 2'd1, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_word(CMD_REPORT, 2'd1, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_word(CMD_SAMPLE, 2'd1, 16'h0101, 16'h7fff, 16'h0f0f, 1'b1, 1'b0);
    send_word(CMD_REPORT, 2'd1, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_word(CMD_SAMPLE, 2'd3, 16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b1);
    send_word(CMD_REPORT, 2'd3, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_word(CMD_SAMPLE, 2'd2, 16'hffff, 16'h0000, 16'h5a5a, 1'b0, 1'b1);
    send_word(CMD_SAMPLE, 2'd2, 16'h0001, 16'h8000, 16'ha5a5, 1'b1, 1'b1);
    send_word(CMD_SAMPLE, 2'd2, 16'h0000, 16'hffff, 16'hc3c3, 1'b1, 1'b1);
    send_word(CMD_REPORT, 2'd2, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_word(CMD_REPORT, 2'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_word(CMD_SAMPLE, 2'd0, 16'h7fff, 16'h7fff, 16'h3c3c, 1'b1, 1'b1);
    send_word(CMD_REPORT, 2'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    drain_records();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 63; end
        default: begin send_idle_pct = 21; recv_stall_pct <= 21; end
      endcase
      while (counted < RANDOM_WORDS * (phase + 1) / 4) begin
        c = ($urandom_range(7) == 0) ? CMD_REPORT : CMD_SAMPLE;
        ch = ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(CHANNELS - 1));
        tv = ($urandom_range(9) != 0);
        wv = ($urandom_range(9) != 0);
        send_word(c, ch, pick_reading(), pick_reading(), pick_reading(), tv, wv);
        if (ch < CHANNELS)
          counted++;
      end
      drain_records();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words: %0d reports, %0d to absent channels, four idle/stall mixes",
             words_sent, reports_sent, ignored_sent);
    $display("compared %0d records, %0d mismatches", records_seen, mismatches);
    if (mismatches == 0 && records_pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
hdl/pcc_pkg.sv
hdl/pcc_update.sv
hdl/pcc_report.sv
hdl/peak_capture_with_companions_unit.sv
test/peak_record_checker.sv
test/tb_peak_capture_with_companions_unit.sv
